[design/psc_pkg.sv]
package psc_pkg;

    // default path length limit
    localparam int PSC_MAX_PATH_BYTES = 4096;

    // dictionary shape
    localparam int PSC_EXACT      = 15;
    localparam int PSC_PATTERNS   = PSC_EXACT + 1;
    localparam int PSC_PREFIX_LEN = 12;
    localparam int PSC_NAME_W     = 13;

    // result field widths
    localparam int PSC_OFF_W = 12;
    localparam int PSC_LEN_W = 13;

    // special bytes
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_MATCH  = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_C_BUILD = 3'd1,
        KIND_RUST    = 3'd2,
        KIND_NODE    = 3'd3,
        KIND_PYTHON  = 3'd4,
        KIND_GO      = 3'd5
    } t_kind;

    typedef logic [8*PSC_NAME_W-1:0] t_name;

    // prefix pattern, first char in the top byte
    localparam logic [8*PSC_PREFIX_LEN-1:0] PREFIX_TEXT = "cmake-build-";

    // exact names, right aligned, earlier entries win
    // underscores inside names are written as octal escapes
    localparam t_name NAME_TEXT [PSC_EXACT] = '{
        ".build", "build", "target", "registry", "node\137modules", ".next", ".turbo",
        "__pycache__", ".pytest\137cache", ".mypy\137cache", ".ruff\137cache", ".venv",
        "venv", "go-build", "gomodcache"
    };

    localparam logic [3:0] NAME_LEN [PSC_EXACT] = '{
        4'd6, 4'd5, 4'd6, 4'd8, 4'd12, 4'd5, 4'd6,
        4'd11, 4'd13, 4'd11, 4'd11, 4'd5, 4'd4,
        4'd8, 4'd10
    };

    localparam t_kind NAME_KIND [PSC_EXACT] = '{
        KIND_C_BUILD, KIND_C_BUILD, KIND_RUST, KIND_RUST, KIND_NODE, KIND_NODE, KIND_NODE,
        KIND_PYTHON, KIND_PYTHON, KIND_PYTHON, KIND_PYTHON, KIND_PYTHON, KIND_PYTHON,
        KIND_GO, KIND_GO
    };

    // char p of exact name k, zero past its end
    function automatic logic [7:0] name_char(input int k, input logic [3:0] p);
        t_name t;
        t = NAME_TEXT[k] << ((PSC_NAME_W - int'(NAME_LEN[k])) * 8);
        if (p >= NAME_LEN[k]) begin
            return 8'h00;
        end
        return t[8*PSC_NAME_W-1 - 8*int'(p) -: 8];
    endfunction

    // char p of the prefix, zero past its end
    function automatic logic [7:0] prefix_char(input logic [3:0] p);
        if (int'(p) >= PSC_PREFIX_LEN) begin
            return 8'h00;
        end
        return PREFIX_TEXT[8*PSC_PREFIX_LEN-1 - 8*int'(p) -: 8];
    endfunction

    // kind of a closed segment from its live patterns and length
    function automatic t_kind classify(input logic [PSC_PATTERNS-1:0] alive,
                                       input logic [3:0] len_lo,
                                       input logic len_ge_prefix,
                                       input logic len_lt16);
        t_kind kind;
        kind = KIND_NONE;
        if (alive[0] && len_ge_prefix) begin
            kind = KIND_C_BUILD;
        end else begin
            for (int k = PSC_EXACT - 1; k >= 0; k--) begin
                if (alive[k+1] && len_lt16 && len_lo == NAME_LEN[k]) begin
                    kind = NAME_KIND[k];
                end
            end
        end
        return kind;
    endfunction

endpackage

[design/psc_in_if.sv]
interface psc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] path_byte;
    logic       last_byte;

    modport source (output valid, output path_byte, output last_byte, input ready);
    modport sink   (input valid, input path_byte, input last_byte, output ready);
endinterface

[design/psc_out_if.sv]
interface psc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  kind;
    logic [11:0] seg_off;
    logic [12:0] seg_len;

    modport source (output valid, output status, output kind, output seg_off,
                    output seg_len, input ready);
    modport sink   (input valid, input status, input kind, input seg_off,
                    input seg_len, output ready);
endinterface

[design/psc_match.sv]
module psc_match
    import psc_pkg::*;
(
    input  logic [7:0]              i_byte,
    input  logic [3:0]              i_pidx,
    input  logic                    i_pidx_ok,
    input  logic [PSC_PATTERNS-1:0] i_alive,
    output logic [PSC_PATTERNS-1:0] o_alive
);

    // prefix only checks its first twelve chars, longer segments keep it
    always_comb begin
        o_alive[0] = i_alive[0];
        if (i_pidx_ok && int'(i_pidx) < PSC_PREFIX_LEN && i_byte != prefix_char(i_pidx)) begin
            o_alive[0] = 1'b0;
        end
    end

    // exact names die past their length or on a mismatch
    always_comb begin
        for (int k = 0; k < PSC_EXACT; k++) begin
            o_alive[k+1] = i_alive[k+1] && i_pidx_ok && (i_pidx < NAME_LEN[k])
                           && (i_byte == name_char(k, i_pidx));
        end
    end

endmodule

[design/path_segment_cache_classifier.sv]
// channel   | dir | payload                                          | handshake
// i_path    | in  | path_byte[7:0], last_byte                        | valid/ready
// o_result  | out | status[1:0], kind[2:0], seg_off[11:0],           | valid/ready
//           |     | seg_len[12:0]                                    |
//
// one byte per cycle sustained; a byte is registered on acceptance and classified from the
// input register, and a result word is registered when its last byte is classified.
// the per-pattern match bits and segment length update in one pass per byte.
// reset is synchronous active low and returns to an empty path.
// a stalled result word only stalls the input when a further last byte reaches the
// processing register; ordinary bytes keep flowing.
module path_segment_cache_classifier
    import psc_pkg::*;
#(
    parameter int MAX_PATH_BYTES = PSC_MAX_PATH_BYTES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    psc_in_if.sink          i_path,
    psc_out_if.source       o_result
);

    localparam int PW = $clog2(MAX_PATH_BYTES + 1);
    localparam int LW = (PW > PSC_LEN_W) ? PW : PSC_LEN_W;
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_PATH_BYTES);

    // input register
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_last;

    // path state
    logic [PW-1:0]           r_pos, n_pos;
    logic [PW-1:0]           r_seg_start, n_seg_start;
    logic [PSC_PATTERNS-1:0] r_alive, n_alive;
    logic                    r_matched, n_matched;
    logic                    r_rejected, n_rejected;
    t_kind                   r_kind, n_kind;
    logic [PSC_OFF_W-1:0]    r_off, n_off;
    logic [PSC_LEN_W-1:0]    r_len, n_len;

    // output register
    logic                 r_out_valid;
    t_status              r_out_status;
    t_kind                r_out_kind;
    logic [PSC_OFF_W-1:0] r_out_off;
    logic [PSC_LEN_W-1:0] r_out_len;

    logic                    advance;
    logic                    active;
    logic                    over;
    logic                    is_slash;
    logic                    is_bad;
    logic [PW-1:0]           len_cur;
    logic [PW-1:0]           close_len;
    logic [PSC_PATTERNS-1:0] alive_adv;
    logic [PSC_PATTERNS-1:0] close_alive;
    logic                    do_close;
    t_kind                   close_kind;
    logic                    hit;
    logic [LW-1:0]           wide_start;
    logic [LW-1:0]           wide_len;

    // handshake
    assign advance        = r_in_valid && (!r_last || !r_out_valid || o_result.ready);
    assign i_path.ready   = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_path.valid && i_path.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_path.valid && i_path.ready) begin
            r_byte <= i_path.path_byte;
            r_last <= i_path.last_byte;
        end
    end

    // byte decode
    assign active   = !r_matched && !r_rejected;
    assign over     = r_pos >= POS_MAX;
    assign is_slash = r_byte == CHAR_SLASH;
    assign is_bad   = r_byte == CHAR_NUL || r_byte == CHAR_BSLASH;
    assign len_cur  = r_pos - r_seg_start;

    // pattern advance
    psc_match u_match (
        .i_byte    (r_byte),
        .i_pidx    (len_cur[3:0]),
        .i_pidx_ok (len_cur < PW'(16)),
        .i_alive   (r_alive),
        .o_alive   (alive_adv)
    );

    // segment close at a slash or at the end of the path
    assign close_alive = is_slash ? r_alive : alive_adv;
    assign close_len   = is_slash ? len_cur : len_cur + PW'(1);
    assign do_close    = active && !over && !is_bad && (is_slash || r_last);
    assign close_kind  = classify(close_alive, close_len[3:0],
                                  close_len >= PW'(PSC_PREFIX_LEN), close_len < PW'(16));
    assign hit         = do_close && close_len != '0 && close_kind != KIND_NONE;
    assign wide_start  = LW'(r_seg_start);
    assign wide_len    = LW'(close_len);

    // next path state
    always_comb begin
        n_pos       = (r_pos < POS_MAX) ? r_pos + PW'(1) : r_pos;
        n_seg_start = r_seg_start;
        n_alive     = r_alive;
        n_matched   = r_matched;
        n_rejected  = r_rejected;
        n_kind      = r_kind;
        n_off       = r_off;
        n_len       = r_len;
        if (active) begin
            if (over || is_bad) begin
                n_rejected = 1'b1;
            end else if (hit) begin
                n_matched = 1'b1;
                n_kind    = close_kind;
                n_off     = wide_start[PSC_OFF_W-1:0];
                n_len     = wide_len[PSC_LEN_W-1:0];
            end else if (is_slash) begin
                n_seg_start = r_pos + PW'(1);
                n_alive     = '1;
            end else begin
                n_alive = alive_adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_seg_start <= '0;
            r_alive     <= '1;
            r_matched   <= 1'b0;
            r_rejected  <= 1'b0;
        end else if (advance && r_last) begin
            r_pos       <= '0;
            r_seg_start <= '0;
            r_alive     <= '1;
            r_matched   <= 1'b0;
            r_rejected  <= 1'b0;
        end else if (advance) begin
            r_pos       <= n_pos;
            r_seg_start <= n_seg_start;
            r_alive     <= n_alive;
            r_matched   <= n_matched;
            r_rejected  <= n_rejected;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_kind <= n_kind;
            r_off  <= n_off;
            r_len  <= n_len;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_last) begin
            if (n_matched) begin
                r_out_status <= ST_MATCH;
                r_out_kind   <= n_kind;
                r_out_off    <= n_off;
                r_out_len    <= n_len;
            end else begin
                r_out_status <= n_rejected ? ST_REJECT : ST_NONE;
                r_out_kind   <= KIND_NONE;
                r_out_off    <= '0;
                r_out_len    <= '0;
            end
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.status  = r_out_status;
    assign o_result.kind    = r_out_kind;
    assign o_result.seg_off = r_out_off;
    assign o_result.seg_len = r_out_len;

`ifndef SYNTHESIS
    // a match never coexists with a reject
    a_match_xor_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_matched && r_rejected))
        else $error("path both matched and rejected");

    // a matched result always carries a kind and a nonempty segment
    a_match_has_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == ST_MATCH |-> r_out_kind != KIND_NONE && r_out_len != '0)
        else $error("match result without kind or length");

    // unmatched results carry zero fields
    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != ST_MATCH
            |-> r_out_kind == KIND_NONE && r_out_off == '0 && r_out_len == '0)
        else $error("unmatched result with nonzero fields");

    // the end of a path returns to an empty path
    a_path_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_last |=> r_pos == '0 && r_alive == '1 && r_out_valid)
        else $error("path state not restarted after last byte");
`endif

endmodule

[dv/path_segment_cache_classifier_tb.sv]
module path_segment_cache_classifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psc_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int RANDOM_BYTES = 1580;

    typedef logic [7:0] t_path[$];

    typedef struct {
        t_status     status;
        t_kind       kind;
        logic [11:0] offset;
        logic [12:0] len;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;

    psc_in_if  path_if();
    psc_out_if res_if();

    path_segment_cache_classifier u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_path   (path_if),
        .o_result (res_if)
    );

    // dictionary, in priority order; underscores inside names as octal escapes
    string cmake_prefix = "cmake-build-";
    string path_chars   = "abcdefghijklmnopqrstuvwxyz0123456789._-";
    string dict_text [PSC_EXACT] = '{
        ".build", "build", "target", "registry", "node\137modules", ".next", ".turbo",
        "__pycache__", ".pytest\137cache", ".mypy\137cache", ".ruff\137cache", ".venv",
        "venv", "go-build", "gomodcache"
    };
    t_kind dict_kind [PSC_EXACT] = '{
        KIND_C_BUILD, KIND_C_BUILD, KIND_RUST, KIND_RUST, KIND_NODE, KIND_NODE, KIND_NODE,
        KIND_PYTHON, KIND_PYTHON, KIND_PYTHON, KIND_PYTHON, KIND_PYTHON, KIND_PYTHON,
        KIND_GO, KIND_GO
    };

    // path tracker state
    int unsigned        trk_pos;
    int unsigned        trk_seg_start;
    logic [15:0]        trk_alive;
    bit                 trk_matched;
    bit                 trk_rejected;
    t_kind              trk_kind;
    logic [11:0]        trk_off;
    logic [12:0]        trk_len;

    t_verdict    pending_verdicts[$];
    int unsigned n_fail      = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_pct   = 0;
    int unsigned gap_max     = 0;
    int unsigned burst_left  = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void tracker_reset();
        trk_pos       = 0;
        trk_seg_start = 0;
        trk_alive     = '1;
        trk_matched   = 1'b0;
        trk_rejected  = 1'b0;
        trk_kind      = KIND_NONE;
        trk_off       = '0;
        trk_len       = '0;
    endfunction

    function automatic void tracker_latch(input t_kind kind, input int unsigned seg_bytes);
        trk_matched = 1'b1;
        trk_kind    = kind;
        trk_off     = 12'(trk_seg_start);
        trk_len     = 13'(seg_bytes);
    endfunction

    // classify the segment ending before seg_end
    function automatic void tracker_close(input int unsigned seg_end);
        int unsigned seg_bytes;
        if (seg_end <= trk_seg_start) begin
            return;
        end
        seg_bytes = seg_end - trk_seg_start;
        if (trk_alive[0] && seg_bytes >= cmake_prefix.len()) begin
            tracker_latch(KIND_C_BUILD, seg_bytes);
            return;
        end
        for (int k = 0; k < PSC_EXACT; k++) begin
            if (trk_alive[k+1] && seg_bytes == dict_text[k].len()) begin
                tracker_latch(dict_kind[k], seg_bytes);
                return;
            end
        end
    endfunction

    // one path byte; returns 1 when a verdict is due
    function automatic bit tracker_step(input logic [7:0] b, input logic last,
                                        output t_verdict v);
        int unsigned pos;
        int unsigned p;
        pos = trk_pos;
        v   = '{ST_NONE, KIND_NONE, '0, '0};
        if (!trk_matched && !trk_rejected) begin
            if (pos >= PSC_MAX_PATH_BYTES) begin
                trk_rejected = 1'b1;
            end else if (b == CHAR_SLASH) begin
                tracker_close(pos);
                if (!trk_matched) begin
                    trk_seg_start = pos + 1;
                    trk_alive     = '1;
                end
            end else if (b == CHAR_NUL || b == CHAR_BSLASH) begin
                trk_rejected = 1'b1;
            end else begin
                p = (pos >= trk_seg_start) ? pos - trk_seg_start : 0;
                if (p < cmake_prefix.len() && cmake_prefix[p] != b) begin
                    trk_alive[0] = 1'b0;
                end
                for (int k = 0; k < PSC_EXACT; k++) begin
                    if (p >= dict_text[k].len() || dict_text[k][p] != b) begin
                        trk_alive[k+1] = 1'b0;
                    end
                end
            end
            if (last && !trk_matched && !trk_rejected) begin
                tracker_close(pos + 1);
            end
        end
        if (trk_pos < PSC_MAX_PATH_BYTES) begin
            trk_pos++;
        end
        if (!last) begin
            return 1'b0;
        end
        if (trk_matched) begin
            v = '{ST_MATCH, trk_kind, trk_off, trk_len};
        end else if (trk_rejected) begin
            v.status = ST_REJECT;
        end
        tracker_reset();
        return 1'b1;
    endfunction

    function automatic t_path path_of(input string s);
        t_path q;
        for (int i = 0; i < s.len(); i++) begin
            q.push_back(s[i]);
        end
        return q;
    endfunction

    function automatic logic [7:0] rand_char();
        return path_chars[$urandom_range(0, path_chars.len() - 1)];
    endfunction

    // send one word, bursts with random gaps in between
    task automatic send_word(input logic [7:0] b, input logic last);
        t_verdict    v;
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, gap_max);
            if (gap != 0) begin
                path_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        path_if.valid     <= 1'b1;
        path_if.path_byte <= b;
        path_if.last_byte <= last;
        @(posedge i_clk);
        while (path_if.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        if (tracker_step(b, last, v)) begin
            pending_verdicts.push_back(v);
        end
    endtask

    task automatic send_path(input t_path p);
        for (int i = 0; i < p.size(); i++) begin
            send_word(p[i], i == p.size() - 1);
        end
    endtask

    // every exact name alone, and some names inside longer paths
    task automatic test_dictionary();
        stall_pct = 0;
        gap_max   = 0;
        foreach (dict_text[k]) begin
            send_path(path_of(dict_text[k]));
        end
        send_path(path_of("src/node\137modules/x"));
        send_path(path_of("target/build"));
        send_path(path_of("a/b/.pytest\137cache"));
        send_path(path_of("targets/venv2/builds"));
    endtask

    // cmake-build- prefix, exact length and longer, near misses
    task automatic test_prefix();
        stall_pct = 50;
        gap_max   = 2;
        send_path(path_of("cmake-build-"));
        send_path(path_of("cmake-build-release/x"));
        send_path(path_of("cmake-build"));
        send_path(path_of("xcmake-build-debug"));
        send_path(path_of("src/cmake-build-d"));
    endtask

    // nul and backslash before and after a match, high-bit bytes
    task automatic test_bad_bytes();
        stall_pct = 20;
        gap_max   = 4;
        send_path({CHAR_NUL});
        send_path({CHAR_BSLASH});
        send_path(path_of("ab\\cd/build"));
        send_path({path_of("build/"), CHAR_NUL});
        send_path({path_of("bu"), CHAR_NUL, path_of("ild")});
        send_path({8'hFF, path_of("/venv")});
    endtask

    // leading, doubled and trailing slashes
    task automatic test_empty_segments();
        stall_pct = 80;
        gap_max   = 0;
        send_path(path_of("/"));
        send_path(path_of("//build"));
        send_path(path_of("build/"));
        send_path(path_of("a//venv/"));
        send_path(path_of("///"));
    endtask

    // random paths, about half of whose segments are dictionary-like
    task automatic test_random_paths();
        t_path       path;
        t_path       seg;
        int unsigned n_bytes;
        int unsigned n_paths;
        int unsigned n_seg;
        int unsigned pick;
        n_bytes = 0;
        n_paths = 0;
        while (n_bytes < RANDOM_BYTES) begin
            // change traffic shape now and then
            if (n_paths % 16 == 0) begin
                case ($urandom_range(0, 3))
                    0: begin
                        stall_pct = 0;
                        gap_max   = 0;
                    end
                    1: begin
                        stall_pct = 30;
                        gap_max   = 3;
                    end
                    2: begin
                        stall_pct = 75;
                        gap_max   = 1;
                    end
                    default: begin
                        stall_pct = $urandom_range(0, 90);
                        gap_max   = $urandom_range(0, 8);
                    end
                endcase
            end
            path = {};
            if ($urandom_range(0, 3) == 0) begin
                path.push_back(CHAR_SLASH);
            end
            n_seg = $urandom_range(1, 5);
            for (int s = 0; s < n_seg; s++) begin
                if (s != 0) begin
                    path.push_back(CHAR_SLASH);
                end
                pick = $urandom_range(0, 99);
                seg  = {};
                if (pick < 30) begin
                    seg = path_of(dict_text[$urandom_range(0, PSC_EXACT - 1)]);
                end else if (pick < 40) begin
                    // near miss of a name
                    seg = path_of(dict_text[$urandom_range(0, PSC_EXACT - 1)]);
                    case ($urandom_range(0, 2))
                        0:       seg[$urandom_range(0, seg.size() - 1)] = rand_char();
                        1:       void'(seg.pop_back());
                        default: seg.push_back(rand_char());
                    endcase
                end else if (pick < 50) begin
                    seg = path_of(cmake_prefix);
                    repeat ($urandom_range(0, 6)) seg.push_back(rand_char());
                    if ($urandom_range(0, 4) == 0) begin
                        seg[$urandom_range(0, 11)] = rand_char();
                    end
                end else if (pick < 78) begin
                    repeat ($urandom_range(1, 10)) seg.push_back(rand_char());
                end else if (pick < 86) begin
                    // empty segment
                end else if (pick < 96) begin
                    repeat ($urandom_range(1, 4)) seg.push_back(8'($urandom_range(0, 255)));
                end else begin
                    seg.push_back($urandom_range(0, 1) ? CHAR_NUL : CHAR_BSLASH);
                end
                path = {path, seg};
            end
            if ($urandom_range(0, 6) == 0) begin
                path.push_back(CHAR_SLASH);
            end
            if (path.size() == 0) begin
                path.push_back(rand_char());
            end
            send_path(path);
            n_bytes += path.size();
            n_paths++;
        end
    endtask

    // result sink, stalls in random stretches
    initial begin : result_sink
        int unsigned hold;
        hold         = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold == 0) begin
                hold = $urandom_range(1, 12);
                res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end else begin
                hold--;
            end
        end
    end

    // compare each result word with the oldest pending verdict
    always @(posedge i_clk) begin : result_check
        t_verdict want;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) begin
                    $display("unexpected result word: status %0d kind %0d off %0d len %0d",
                             res_if.status, res_if.kind, res_if.seg_off,
                             res_if.seg_len);
                end
            end else begin
                want = pending_verdicts.pop_front();
                if (res_if.status !== want.status || res_if.kind !== want.kind ||
                    res_if.seg_off !== want.offset ||
                    res_if.seg_len !== want.len) begin
                    n_fail++;
                    if (n_fail <= 10) begin
                        $display("mismatch (exp/act): status %0d/%0d kind %0d/%0d",
                                 want.status, res_if.status, want.kind, res_if.kind);
                        $display("    off %0d/%0d len %0d/%0d",
                                 want.offset, res_if.seg_off,
                                 want.len, res_if.seg_len);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no word accepted on either side
    always @(posedge i_clk) begin
        if ((path_if.valid === 1'b1 && path_if.ready === 1'b1) ||
            (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("timeout: no word accepted for %0d cycles", IDLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    // test sequence
    initial begin
        i_rst_n           = 1'b0;
        path_if.valid     = 1'b0;
        path_if.path_byte = '0;
        path_if.last_byte = 1'b0;
        tracker_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_dictionary();
        test_prefix();
        test_bad_bytes();
        test_empty_segments();
        test_random_paths();
        path_if.valid <= 1'b0;

        // drain outstanding verdicts
        while (pending_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (n_fail == 0 && pending_verdicts.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
